[rtl/core/xadpcm_pkg.sv]
// Shared types, constants and coefficient tables for the ADPCM stream decoder.
`default_nettype none
package xadpcm_pkg;

	localparam int SAMPLES_PER_CHUNK = 28;
	localparam logic [7:0] RAW_HEADER = 8'hEE;
	// last byte position of a raw chunk: four history bytes, then two bytes per sample
	localparam logic [5:0] RAW_LAST_POS = 6'(4 + 2 * SAMPLES_PER_CHUNK);
	// last byte position of a compressed chunk: two samples per data byte
	localparam logic [5:0] NIB_LAST_POS = 6'(SAMPLES_PER_CHUNK / 2);
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		OP_NEWER,
		OP_OLDER,
		OP_RAW,
		OP_NIB
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [15:0] data;
		logic [1:0]  coef;
		logic [3:0]  expo;
		logic        clamp;
		logic        last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_ACC
	} back_state_t;

	// weight of the newer sample, in 1/64 units
	function automatic logic signed [7:0] coef_newer(input logic [1:0] sel);
		logic signed [7:0] c;
		unique case (sel)
			2'd0: c = 8'sd0;
			2'd1: c = 8'sd60;
			2'd2: c = 8'sd115;
			2'd3: c = 8'sd98;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

	// weight of the older sample, in 1/64 units
	function automatic logic signed [7:0] coef_older(input logic [1:0] sel);
		logic signed [7:0] c;
		unique case (sel)
			2'd0: c = 8'sd0;
			2'd1: c = 8'sd0;
			2'd2: c = -8'sd52;
			2'd3: c = -8'sd55;
			default: c = 8'sd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[rtl/core/xadpcm_front.sv]
// Front end: parses chunk framing byte by byte and queues work for the back end.
`default_nettype none
module xadpcm_front
	import xadpcm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire logic [7:0] in_byte,
	input  wire q_status_t qs,
	output logic           push,
	output q_entry_t       entry
);

	logic [5:0] pos_q;
	logic       raw_q;
	logic [1:0] coef_q;
	logic [3:0] expo_q;
	logic       ovf_q;
	logic [7:0] held_q;
	logic       accept;

	assign in_ready = !qs.full;
	assign accept   = in_valid && in_ready;

	// classify the beat into a queue entry
	always_comb begin
		push        = 1'b0;
		entry.kind  = OP_NIB;
		entry.data  = {8'h00, in_byte};
		entry.coef  = coef_q;
		entry.expo  = expo_q;
		entry.clamp = ovf_q;
		entry.last  = 1'b0;
		if (accept && pos_q != 6'd0) begin
			if (raw_q) begin
				entry.data  = {held_q, in_byte};
				entry.clamp = 1'b0;
				entry.last  = pos_q >= RAW_LAST_POS;
				if (!pos_q[0]) begin
					push = 1'b1;
					if (pos_q == 6'd2) begin
						entry.kind = OP_NEWER;
					end else if (pos_q == 6'd4) begin
						entry.kind = OP_OLDER;
					end else begin
						entry.kind = OP_RAW;
					end
				end
			end else begin
				push       = 1'b1;
				entry.last = pos_q >= NIB_LAST_POS;
			end
		end
	end

	// advance the framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 6'd0;
			raw_q  <= 1'b0;
			coef_q <= 2'd0;
			expo_q <= 4'd0;
			ovf_q  <= 1'b0;
			held_q <= 8'd0;
		end else if (accept) begin
			if (pos_q == 6'd0) begin
				pos_q <= 6'd1;
				if (in_byte == RAW_HEADER) begin
					raw_q <= 1'b1;
					ovf_q <= 1'b0;
				end else begin
					raw_q  <= 1'b0;
					coef_q <= in_byte[5:4];
					ovf_q  <= in_byte[7:6] != 2'd0;
					expo_q <= in_byte[3:0];
				end
			end else if (raw_q) begin
				pos_q <= (pos_q >= RAW_LAST_POS) ? 6'd0 : pos_q + 6'd1;
				if (pos_q[0]) begin
					held_q <= in_byte;
				end
			end else begin
				pos_q <= (pos_q >= NIB_LAST_POS) ? 6'd0 : pos_q + 6'd1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/xadpcm_queue.sv]
// Short queue between the parsing front end and the decoding back end.
`default_nettype none
module xadpcm_queue
	import xadpcm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t wr_entry,
	input  wire logic     pop,
	output q_entry_t      head,
	output q_status_t     qs
);

	localparam int PTR_W = $clog2(QDEPTH);

	q_entry_t         mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign head     = mem_q[rd_ptr_q];
	assign qs.full  = count_q == (PTR_W + 1)'(QDEPTH);
	assign qs.empty = count_q == '0;

	// store the incoming entry
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/xadpcm_back.sv]
// Back end: applies history loads, passes raw samples and runs the predictor.
`default_nettype none
module xadpcm_back
	import xadpcm_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire q_entry_t    head,
	input  wire q_status_t   qs,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] sample,
	output logic             run_last,
	output logic             chunk_last,
	output logic             coef_clamped
);

	localparam int PROD_W = 24;
	localparam int ACC_W  = FRAC_BITS + 20;
	localparam int RES_W  = ACC_W - FRAC_BITS;
	localparam int SH_W   = $clog2(FRAC_BITS + 13);
	localparam logic signed [ACC_W-1:0] ROUND  = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [RES_W-1:0] SAT_HI = RES_W'(32767);
	localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-32768);

	back_state_t state_q, state_d;
	q_entry_t    op_q;
	logic        half_q;
	logic signed [15:0]       newer_q, older_q;
	logic signed [PROD_W-1:0] p0_q, p1_q;
	logic        out_valid_q;
	logic        slot_free;
	logic        ld_op, ld_newer, ld_older, emit_raw, emit_pred;
	logic signed [3:0]       nib;
	logic [SH_W-1:0]         sh;
	logic signed [ACC_W-1:0] acc;
	logic signed [RES_W-1:0] res;
	logic signed [15:0]      pred;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!qs.empty && head.kind == OP_NIB) begin
					state_d = BK_MUL;
				end
			end
			BK_MUL: state_d = BK_ACC;
			BK_ACC: begin
				if (slot_free) begin
					state_d = half_q ? BK_IDLE : BK_MUL;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		pop       = 1'b0;
		ld_op     = 1'b0;
		ld_newer  = 1'b0;
		ld_older  = 1'b0;
		emit_raw  = 1'b0;
		emit_pred = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!qs.empty) begin
					unique case (head.kind)
						OP_NEWER: begin
							pop      = 1'b1;
							ld_newer = 1'b1;
						end
						OP_OLDER: begin
							pop      = 1'b1;
							ld_older = 1'b1;
						end
						OP_RAW: begin
							pop      = slot_free;
							emit_raw = slot_free;
						end
						OP_NIB: begin
							pop   = 1'b1;
							ld_op = 1'b1;
						end
						default: pop = 1'b0;
					endcase
				end
			end
			BK_ACC:  emit_pred = slot_free;
			default: pop = 1'b0;
		endcase
	end

	// accumulate, round and clip one prediction
	always_comb begin
		nib  = half_q ? op_q.data[3:0] : op_q.data[7:4];
		sh   = SH_W'(12 + FRAC_BITS) - SH_W'(op_q.expo);
		acc  = ((ACC_W'(p0_q) + ACC_W'(p1_q)) <<< (FRAC_BITS - 6))
		     + (ACC_W'(nib) <<< sh) + ROUND;
		res  = RES_W'(acc >>> FRAC_BITS);
		if (res > SAT_HI) begin
			pred = 16'sh7FFF;
		end else if (res < SAT_LO) begin
			pred = -16'sh8000;
		end else begin
			pred = res[15:0];
		end
	end

	// control state and predictor history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			half_q      <= 1'b0;
			newer_q     <= '0;
			older_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_op) begin
				half_q <= 1'b0;
			end else if (emit_pred) begin
				half_q <= ~half_q;
			end
			if (ld_newer) begin
				newer_q <= head.data;
			end else if (ld_older) begin
				older_q <= head.data;
			end else if (emit_pred) begin
				older_q <= newer_q;
				newer_q <= pred;
			end
			if (emit_raw || emit_pred) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the op, the products and the output beat
	always_ff @(posedge clk) begin
		if (ld_op) begin
			op_q <= head;
		end
		if (state_q == BK_MUL) begin
			p0_q <= newer_q * coef_newer(op_q.coef);
			p1_q <= older_q * coef_older(op_q.coef);
		end
		if (emit_raw) begin
			sample       <= head.data;
			run_last     <= 1'b1;
			chunk_last   <= head.last;
			coef_clamped <= 1'b0;
		end else if (emit_pred) begin
			sample       <= pred;
			run_last     <= half_q;
			chunk_last   <= half_q && op_q.last;
			coef_clamped <= op_q.clamp;
		end
	end

endmodule
`default_nettype wire

[rtl/core/xa_r2_adpcm_stream_decoder_unit.sv]
// A compressed byte passes the queue, the op register and the product registers to the output register,
// its second sample after another multiply and accumulate step; a raw low byte passes only the queue.
// Each compressed byte takes a load step, then a multiply and an accumulate step per sample through
// one shared predictor, which waits while the output stalls and ends a byte before loading the next.
// A two-entry queue lets the front keep taking bytes while the predictor works.
// Reset clears framing state, queue, output valid and the predictor history to zero.
`default_nettype none
module xa_r2_adpcm_stream_decoder_unit
	import xadpcm_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] sample,
	output logic             run_last,
	output logic             chunk_last,
	output logic             coef_clamped
);

	q_status_t qs;
	q_entry_t  wr_entry;
	q_entry_t  head;
	logic      push;
	logic      pop;

	xadpcm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.qs       (qs),
		.push     (push),
		.entry    (wr_entry)
	);

	xadpcm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.qs       (qs)
	);

	xadpcm_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qs           (qs),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sample       (sample),
		.run_last     (run_last),
		.chunk_last   (chunk_last),
		.coef_clamped (coef_clamped)
	);

	// never write a full queue
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !qs.full)
		else $error("queue written while full");

	// never read an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !qs.empty)
		else $error("queue read while empty");

	// the first sample of a data byte never closes a chunk
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !run_last) |-> !chunk_last)
		else $error("chunk end flagged on first sample of a byte");

	// a chunk end on an unclamped sample always closes the run of its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && chunk_last && !coef_clamped) |-> run_last)
		else $error("chunk end without run end");

endmodule
`default_nettype wire
